// File: src/rgb_box_average_decimator_macros.svh
// ----------------------------------------------------------------------------
// rgb_box_average_decimator_macros.svh
// Assertion shorthands for the box-average decimator, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_AVERAGE_DECIMATOR_MACROS_SVH
`define RGB_BOX_AVERAGE_DECIMATOR_MACROS_SVH

// same-cycle implication
`define RBAD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RBAD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rbad_pkg.sv
// ----------------------------------------------------------------------------
// rbad_pkg
// Shared widths, register map, reset values and types of the decimator.
// ----------------------------------------------------------------------------
package rbad_pkg;

	localparam int CH_W           = 8;
	localparam int NUM_CH         = 3;
	localparam int FACTOR_W       = 5;
	localparam int WIDTH_W        = 12;
	localparam int HEIGHT_W       = 16;
	localparam int REG_IDX_W      = 2;
	localparam int APB_AW         = REG_IDX_W + 2;
	localparam int APB_DW         = 32;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_FACTOR_DEF = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DIRECTION,
		REG_FACTOR,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic                direction;
		logic [FACTOR_W-1:0] factor;
		logic [WIDTH_W-1:0]  image_width;
		logic [HEIGHT_W-1:0] image_height;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		direction:    1'b0,
		factor:       FACTOR_W'(2),
		image_width:  WIDTH_W'(2048),
		image_height: HEIGHT_W'(1)
	};

	typedef struct packed {
		logic eor;
		logic eof;
	} tag_t;

	typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

endpackage

// File: src/rbad_pix_if.sv
// ----------------------------------------------------------------------------
// rbad_pix_if
// Input pixel channel: valid/ready handshake with one RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface rbad_pix_if;

	logic                      valid;
	logic                      ready;
	logic [rbad_pkg::CH_W-1:0] red_in;
	logic [rbad_pkg::CH_W-1:0] green_in;
	logic [rbad_pkg::CH_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);

endinterface

// File: src/rbad_avg_if.sv
// ----------------------------------------------------------------------------
// rbad_avg_if
// Output channel: one averaged pixel with row and frame markers per transfer.
// ----------------------------------------------------------------------------
interface rbad_avg_if;

	logic                      valid;
	logic                      ready;
	logic [rbad_pkg::CH_W-1:0] red_avg;
	logic [rbad_pkg::CH_W-1:0] green_avg;
	logic [rbad_pkg::CH_W-1:0] blue_avg;
	logic                      end_of_row;
	logic                      end_of_frame;

	modport source (
		output valid, output red_avg, output green_avg, output blue_avg,
		output end_of_row, output end_of_frame, input ready
	);
	modport sink (
		input valid, input red_avg, input green_avg, input blue_avg,
		input end_of_row, input end_of_frame, output ready
	);

endinterface

// File: src/rbad_ram.sv
// ----------------------------------------------------------------------------
// rbad_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbad_ram #(
	parameter int WIDTH = rbad_pkg::NUM_CH * rbad_pkg::CH_W,
	parameter int DEPTH = rbad_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/rbad_cfg.sv
// ----------------------------------------------------------------------------
// rbad_cfg
// APB register file; any write pulses restart for the frame position logic.
// ----------------------------------------------------------------------------
module rbad_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbad_pkg::APB_AW-1:0]   paddr,
	input  logic [rbad_pkg::APB_DW-1:0]   pwdata,
	output logic [rbad_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output rbad_pkg::cfg_t                cfg,
	output logic                          restart
);

	localparam int DW = rbad_pkg::APB_DW;
	localparam int FW = rbad_pkg::FACTOR_W;
	localparam int WW = rbad_pkg::WIDTH_W;
	localparam int HW = rbad_pkg::HEIGHT_W;

	rbad_pkg::cfg_t     cfg_q;
	rbad_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx     = rbad_pkg::reg_idx_t'(paddr[rbad_pkg::APB_AW-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign restart = wr_en;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rbad_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				rbad_pkg::REG_DIRECTION: cfg_q.direction    <= pwdata[0];
				rbad_pkg::REG_FACTOR:    cfg_q.factor       <= pwdata[FW-1:0];
				rbad_pkg::REG_WIDTH:     cfg_q.image_width  <= pwdata[WW-1:0];
				rbad_pkg::REG_HEIGHT:    cfg_q.image_height <= pwdata[HW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rbad_pkg::REG_DIRECTION: prdata = DW'(cfg_q.direction);
			rbad_pkg::REG_FACTOR:    prdata = DW'(cfg_q.factor);
			rbad_pkg::REG_WIDTH:     prdata = DW'(cfg_q.image_width);
			rbad_pkg::REG_HEIGHT:    prdata = DW'(cfg_q.image_height);
			default:                 prdata = '0;
		endcase
	end

endmodule

// File: src/rbad_accum.sv
// ----------------------------------------------------------------------------
// rbad_accum
// Frame position tracking, horizontal running sum and the vertical column-sum
// line memory (read at transfer, add and write back in stage 1 when it advances).
// ----------------------------------------------------------------------------
module rbad_accum #(
	parameter int MAX_WIDTH  = rbad_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = rbad_pkg::MAX_FACTOR_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  rbad_pkg::cfg_t                                        cfg,
	input  logic                                                  restart,
	input  logic                                                  accept,
	input  rbad_pkg::rgb_t                                        px,
	input  logic                                                  adv,
	output logic                                                  sum_valid,
	output logic [rbad_pkg::NUM_CH-1:0][$clog2(MAX_FACTOR*255+1)-1:0] sum,
	output rbad_pkg::tag_t                                        sum_tag,
	output logic [$clog2(MAX_FACTOR+1)-1:0]                       factor_eff
);

	localparam int NCH   = rbad_pkg::NUM_CH;
	localparam int HW    = rbad_pkg::HEIGHT_W;
	localparam int SUM_W = $clog2(MAX_FACTOR*255+1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH+1);
	localparam int MW    = $clog2(MAX_FACTOR+1);
	localparam int FW    = $clog2(MAX_FACTOR);
	localparam int XW    = $clog2(MAX_WIDTH+MAX_FACTOR+1);
	localparam int YW    = $clog2((2**HW)+MAX_FACTOR);

	typedef logic [NCH-1:0][SUM_W-1:0] sums_t;

	logic [MW-1:0] m_eff;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [FW-1:0] fill_q;
	sums_t         rsum_q;

	logic [CW-1:0] col_e;
	logic [HW-1:0] row_e;
	logic          last_col;
	logic          last_row;
	logic [MW-1:0] fill_inc;
	logic          close;
	logic          h_incl;
	logic          h_eor;
	logic          v_incl;
	logic          v_eof;
	sums_t         rsum_add;

	logic [CW-1:0]  nxt_col;
	logic [HW-1:0]  nxt_row;
	logic [FW-1:0]  nxt_fill;
	sums_t          nxt_rsum;
	logic           emit;
	logic           vwr;
	rbad_pkg::tag_t tag;

	logic           valid_s1;
	logic           emit_s1;
	logic           vwr_s1;
	logic           first_s1;
	logic [CW-1:0]  addr_s1;
	rbad_pkg::rgb_t px_s1;
	sums_t          hsum_s1;
	rbad_pkg::tag_t tag_s1;
	logic           fwd_hit_s1;
	sums_t          fwd_data_s1;

	sums_t          rd_data;
	sums_t          msum;
	logic           mem_we;

	// effective register values
	always_comb begin
		if (cfg.factor == '0) begin
			m_eff = MW'(1);
		end else if (32'(cfg.factor) > MAX_FACTOR) begin
			m_eff = MW'(MAX_FACTOR);
		end else begin
			m_eff = MW'(cfg.factor);
		end
		if (cfg.image_width == '0) begin
			w_eff = WW'(1);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.image_width);
		end
		h_eff = (cfg.image_height == '0) ? HW'(1) : cfg.image_height;
	end

	assign factor_eff = m_eff;

	// position and group decisions for the pixel at the port
	always_comb begin
		col_e    = (XW'(col_q) >= XW'(w_eff)) ? CW'(w_eff - WW'(1)) : col_q;
		row_e    = (row_q >= h_eff) ? h_eff - HW'(1) : row_q;
		last_col = XW'(col_e) == XW'(w_eff) - XW'(1);
		last_row = row_e == h_eff - HW'(1);
		fill_inc = MW'(fill_q) + MW'(1);
		close    = fill_inc == m_eff;
		// group start plus factor must stay inside the row or frame
		h_incl   = XW'(col_e) - XW'(fill_q) + XW'(m_eff) <= XW'(w_eff);
		h_eor    = XW'(col_e) + XW'(1) + XW'(m_eff) > XW'(w_eff);
		v_incl   = YW'(row_e) - YW'(fill_q) + YW'(m_eff) <= YW'(h_eff);
		v_eof    = last_col && (YW'(row_e) + YW'(1) + YW'(m_eff) > YW'(h_eff));
		for (int c = 0; c < NCH; c++) begin
			rsum_add[c] = rsum_q[c] + SUM_W'(px[c]);
		end
	end

	always_comb begin
		nxt_col  = col_q;
		nxt_row  = row_q;
		nxt_fill = fill_q;
		nxt_rsum = rsum_q;
		emit     = 1'b0;
		vwr      = 1'b0;
		tag      = '0;
		if (!cfg.direction) begin
			if (h_incl) begin
				if (close) begin
					emit     = 1'b1;
					nxt_rsum = '0;
					nxt_fill = '0;
					tag.eor  = h_eor;
					tag.eof  = h_eor && last_row;
				end else begin
					nxt_rsum = rsum_add;
					nxt_fill = FW'(fill_inc);
				end
			end
			if (last_col) begin
				nxt_fill = '0;
				nxt_rsum = '0;
			end
		end else begin
			if (v_incl) begin
				vwr     = 1'b1;
				emit    = close;
				tag.eor = last_col;
				tag.eof = v_eof;
				if (last_col) begin
					nxt_fill = close ? '0 : FW'(fill_inc);
				end
			end
		end
		if (last_col) begin
			nxt_col = '0;
			if (last_row) begin
				nxt_row  = '0;
				nxt_fill = '0;
				nxt_rsum = '0;
			end else begin
				nxt_row = row_e + HW'(1);
			end
		end else begin
			nxt_col = col_e + CW'(1);
			nxt_row = row_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
			rsum_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
			rsum_q <= '0;
		end else if (accept) begin
			col_q  <= nxt_col;
			row_q  <= nxt_row;
			fill_q <= nxt_fill;
			rsum_q <= nxt_rsum;
		end
	end

	// stage 1: line memory read data arrives, add and write back
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			if (first_s1) begin
				msum[c] = SUM_W'(px_s1[c]);
			end else if (fwd_hit_s1) begin
				msum[c] = fwd_data_s1[c] + SUM_W'(px_s1[c]);
			end else begin
				msum[c] = rd_data[c] + SUM_W'(px_s1[c]);
			end
		end
	end

	assign mem_we = valid_s1 && vwr_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= emit;
			vwr_s1      <= vwr;
			first_s1    <= fill_q == '0;
			addr_s1     <= col_e;
			px_s1       <= px;
			hsum_s1     <= rsum_add;
			tag_s1      <= tag;
			// the entry written this edge is read this edge too
			fwd_hit_s1  <= valid_s1 && vwr_s1 && (addr_s1 == col_e);
			fwd_data_s1 <= msum;
		end
	end

	rbad_ram #(
		.WIDTH(NCH * SUM_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_s1),
		.wdata(msum),
		.re   (accept),
		.raddr(col_e),
		.rdata(rd_data)
	);

	assign sum_valid = valid_s1 && emit_s1;
	assign sum       = vwr_s1 ? msum : hsum_s1;
	assign sum_tag   = tag_s1;

endmodule

// File: src/rbad_div.sv
// ----------------------------------------------------------------------------
// rbad_div
// Pipelined restoring divider, one quotient bit per stage, one lane per
// color channel. Quotient is known to fit in one channel width.
// ----------------------------------------------------------------------------
module rbad_div #(
	parameter int MAX_FACTOR = rbad_pkg::MAX_FACTOR_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  adv,
	input  logic                                                  in_valid,
	input  rbad_pkg::tag_t                                        in_tag,
	input  logic [rbad_pkg::NUM_CH-1:0][$clog2(MAX_FACTOR*255+1)-1:0] in_sum,
	input  logic [$clog2(MAX_FACTOR+1)-1:0]                       divisor,
	output logic                                                  out_valid,
	output rbad_pkg::tag_t                                        out_tag,
	output rbad_pkg::rgb_t                                        out_quo
);

	localparam int NCH  = rbad_pkg::NUM_CH;
	localparam int QW   = rbad_pkg::CH_W;
	localparam int MW   = $clog2(MAX_FACTOR+1);
	localparam int DVW  = MW + QW;
	localparam int NSTG = QW;

	typedef logic [NCH-1:0][DVW-1:0] rems_t;

	logic           vld_p [NSTG];
	rbad_pkg::tag_t tag_p [NSTG];
	rems_t          rem_p [NSTG];
	rbad_pkg::rgb_t quo_p [NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		logic           vld_in;
		rbad_pkg::tag_t tag_in;
		rems_t          rem_in;
		rems_t          rem_nx;
		rbad_pkg::rgb_t quo_in;
		rbad_pkg::rgb_t quo_nx;
		logic [DVW-1:0] trial;
		logic           vld_s;
		rbad_pkg::tag_t tag_s;
		rems_t          rem_s;
		rbad_pkg::rgb_t quo_s;

		if (k == 0) begin : g_head
			always_comb begin
				vld_in = in_valid;
				tag_in = in_tag;
				quo_in = '0;
				for (int c = 0; c < NCH; c++) begin
					rem_in[c] = DVW'(in_sum[c]);
				end
			end
		end else begin : g_body
			always_comb begin
				vld_in = vld_p[k-1];
				tag_in = tag_p[k-1];
				quo_in = quo_p[k-1];
				rem_in = rem_p[k-1];
			end
		end

		assign trial = DVW'(divisor) << (NSTG - 1 - k);

		always_comb begin
			for (int c = 0; c < NCH; c++) begin
				if (rem_in[c] >= trial) begin
					rem_nx[c] = rem_in[c] - trial;
					quo_nx[c] = quo_in[c] | (QW'(1) << (NSTG - 1 - k));
				end else begin
					rem_nx[c] = rem_in[c];
					quo_nx[c] = quo_in[c];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (adv) begin
				vld_s <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s <= tag_in;
				rem_s <= rem_nx;
				quo_s <= quo_nx;
			end
		end

		assign vld_p[k] = vld_s;
		assign tag_p[k] = tag_s;
		assign rem_p[k] = rem_s;
		assign quo_p[k] = quo_s;
	end

	assign out_valid = vld_p[NSTG-1];
	assign out_tag   = tag_p[NSTG-1];
	assign out_quo   = quo_p[NSTG-1];

endmodule

// File: src/rgb_box_average_decimator.sv
// Path: stage 1 (after the registered line-memory read), then the divider stages.
// Throughput: one pixel per cycle unless the output stalls; the line-memory
// read-modify-write closes in stage 1, with one-entry forwarding to the next pixel.
// Reset: asynchronous, clears positions, running sums and pipeline valids;
// the line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// rgb_box_average_decimator
// RGB box-average decimator along rows or columns, truncating mean per group.
// ----------------------------------------------------------------------------
`include "rgb_box_average_decimator_macros.svh"

module rgb_box_average_decimator #(
	parameter int MAX_WIDTH  = rbad_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = rbad_pkg::MAX_FACTOR_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rbad_pkg::APB_AW-1:0] paddr,
	input  logic [rbad_pkg::APB_DW-1:0] pwdata,
	output logic [rbad_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	rbad_pix_if.sink                    pixel,
	rbad_avg_if.source                  average
);

	localparam int NCH   = rbad_pkg::NUM_CH;
	localparam int SUM_W = $clog2(MAX_FACTOR*255+1);
	localparam int MW    = $clog2(MAX_FACTOR+1);

	rbad_pkg::cfg_t             cfg;
	logic                       restart;
	logic                       adv;
	logic                       accept;
	rbad_pkg::rgb_t             px;
	logic                       acc_vld;
	logic [NCH-1:0][SUM_W-1:0]  acc_sum;
	rbad_pkg::tag_t             acc_tag;
	logic [MW-1:0]              factor_eff;
	logic                       div_vld;
	rbad_pkg::tag_t             div_tag;
	rbad_pkg::rgb_t             div_quo;

	assign adv         = !average.valid || average.ready;
	assign pixel.ready = adv;
	assign accept      = pixel.valid && adv;
	assign px          = {pixel.blue_in, pixel.green_in, pixel.red_in};

	rbad_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.restart(restart)
	);

	rbad_accum #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.restart   (restart),
		.accept    (accept),
		.px        (px),
		.adv       (adv),
		.sum_valid (acc_vld),
		.sum       (acc_sum),
		.sum_tag   (acc_tag),
		.factor_eff(factor_eff)
	);

	rbad_div #(
		.MAX_FACTOR(MAX_FACTOR)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (acc_vld),
		.in_tag   (acc_tag),
		.in_sum   (acc_sum),
		.divisor  (factor_eff),
		.out_valid(div_vld),
		.out_tag  (div_tag),
		.out_quo  (div_quo)
	);

	assign average.valid        = div_vld;
	assign average.red_avg      = div_quo[0];
	assign average.green_avg    = div_quo[1];
	assign average.blue_avg     = div_quo[2];
	assign average.end_of_row   = div_tag.eor;
	assign average.end_of_frame = div_tag.eof;

	`RBAD_ASSERT_NOW(a_eof_has_eor, average.valid && average.end_of_frame, average.end_of_row, "end of frame without end of row")
	`RBAD_ASSERT_NEXT(a_div_feed_held, acc_vld && !adv, acc_vld, "divider feed lost while stalled")

endmodule
